FILE: rtl/pds_pkg.sv
// Package for the PLL post divider search: constants, divider pair table and lane types.
// No dependencies; used by pll_ds_lane and pll_divider_search.
package pds_pkg;

    localparam int MAX_POST_DIV = 7;
    localparam int NPAIR        = MAX_POST_DIV * (MAX_POST_DIV + 1) / 2;
    localparam int NSTAGE       = 6;

    localparam logic [31:0] REF_HZ  = 32'd12000000;
    localparam logic [31:0] VCO_MIN = 32'd400000000;
    localparam logic [31:0] VCO_MAX = 32'd1600000000;

    // 12 MHz = 256 * 46875; reciprocal of 46875 scaled by 2^32
    localparam logic [16:0] REF_RECIP = 17'(64'h1_0000_0000 / 64'd46875);

    typedef struct packed {
        logic [2:0] first;
        logic [2:0] second;
    } t_pair;

    typedef struct packed {
        logic        hit;
        logic [7:0]  fb;
        logic [30:0] got;
    } t_lane_res;

    typedef logic [NSTAGE:1] t_lane_en;

    // search order: first from MAX_POST_DIV down, second from first down
    function automatic t_pair pair_of(input int idx);
        int    n;
        t_pair p;
        n = 0;
        p = '0;
        for (int a = MAX_POST_DIV; a >= 1; a--) begin
            for (int b = a; b >= 1; b--) begin
                if (n == idx) begin
                    p.first  = 3'(a);
                    p.second = 3'(b);
                end
                n++;
            end
        end
        return p;
    endfunction

endpackage

FILE: rtl/pll_divider_search.sv
// Top level of the PLL post divider search: pipeline control, lanes and first-hit select.
// Depends on pds_pkg and pll_ds_lane.
//
// Each target frequency item is checked against all 28 post divider pairs in parallel,
// one lane per pair, and the first acceptable pair in search order is reported. One item
// is taken per cycle while a stalled output does not hold the pipeline; the result passes
// through six lane stages, the first loaded at the accepting edge, and then the output
// register. Each stage holds independently, so a stalled output only stops
// the stages that are full. No state survives between items.
module pll_divider_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] requested frequency
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] feedback_divider, [10:8] post_div_one,
                                        // [13:11] post_div_two, [44:14] achieved_hz, zero pad
    output logic        m_axis_tuser    // [0] found
);
    import pds_pkg::*;

    logic [NSTAGE+1:1] r_v;
    logic [NSTAGE+1:1] w_en;
    logic [31:0]       r_tgt [1:5];
    t_lane_res         w_res [NPAIR];

    logic              r_found, n_found;
    logic [7:0]        r_fb, n_fb;
    logic [2:0]        r_d1, n_d1;
    logic [2:0]        r_d2, n_d2;
    logic [30:0]       r_got, n_got;

    always_comb begin
        w_en[NSTAGE+1] = !r_v[NSTAGE+1] || m_axis_tready;
        for (int k = NSTAGE; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NSTAGE + 1; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_tgt[1] <= s_axis_tdata;
        end
        for (int k = 2; k <= 5; k++) begin
            if (w_en[k]) begin
                r_tgt[k] <= r_tgt[k-1];
            end
        end
    end

    for (genvar g = 0; g < NPAIR; g++) begin : g_lane
        localparam t_pair       PAIR  = pair_of(g);
        localparam int          PROD  = int'(PAIR.first) * int'(PAIR.second);
        localparam logic [31:0] RECIP = 32'(64'h0_FFFF_FFFF / 64'(PROD));

        pll_ds_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en[NSTAGE:1]),
            .i_prod  (6'(PROD)),
            .i_recip (RECIP),
            .i_tgt   (s_axis_tdata),
            .i_tgt5  (r_tgt[5]),
            .o_res   (w_res[g])
        );
    end

    always_comb begin
        t_pair p;
        n_found = 1'b0;
        n_fb    = '0;
        n_d1    = '0;
        n_d2    = '0;
        n_got   = '0;
        for (int i = NPAIR - 1; i >= 0; i--) begin
            p = pair_of(i);
            if (w_res[i].hit) begin
                n_found = 1'b1;
                n_fb    = w_res[i].fb;
                n_d1    = p.first;
                n_d2    = p.second;
                n_got   = w_res[i].got;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NSTAGE+1]) begin
            r_found <= n_found;
            r_fb    <= n_fb;
            r_d1    <= n_d1;
            r_d2    <= n_d2;
            r_got   <= n_got;
        end
    end

    assign m_axis_tvalid = r_v[NSTAGE+1];
    assign m_axis_tuser  = r_found;
    assign m_axis_tdata  = {3'b000, r_got, r_d2, r_d1, r_fb};

endmodule

FILE: rtl/pll_ds_lane.sv
// One divider pair lane: VCO range check, feedback divider, achieved frequency, error test.
// Depends on pds_pkg; stage enables come from pll_divider_search.
module pll_ds_lane (
    input  logic               i_clk,
    input  pds_pkg::t_lane_en  i_en,
    input  logic [5:0]         i_prod,
    input  logic [31:0]        i_recip,
    input  logic [31:0]        i_tgt,
    input  logic [31:0]        i_tgt5,
    output pds_pkg::t_lane_res o_res
);
    import pds_pkg::*;

    logic [37:0] w_vco;
    logic        w_inr;
    logic [39:0] w_q;
    logic [8:0]  w_q1;
    logic [39:0] w_lo;
    logic [39:0] w_hi;
    logic        w_ge;
    logic [62:0] w_m;
    logic [36:0] w_qp;
    logic [36:0] w_r;
    logic [30:0] w_got;
    logic [31:0] w_got32;
    logic [31:0] w_err;

    logic        r1_inr, r2_inr, r3_inr, r4_inr, r5_inr;
    logic [30:0] r1_vco, r2_vco;
    logic [7:0]  r2_q0;
    logic [7:0]  r3_fb, r4_fb, r5_fb;
    logic [30:0] r3_fbm, r4_fbm;
    logic [30:0] r4_q0;
    logic [30:0] r5_got;
    t_lane_res   r6_res;

    always_comb begin
        w_vco   = 38'(i_tgt) * 38'(i_prod);
        w_inr   = (w_vco >= 38'(VCO_MIN)) && (w_vco <= 38'(VCO_MAX));
        w_q     = 40'(r1_vco[30:8]) * 40'(REF_RECIP);
        w_q1    = {1'b0, r2_q0} + 9'd1;
        w_lo    = 40'(r2_q0) * 40'(REF_HZ);
        w_hi    = 40'(w_q1) * 40'(REF_HZ);
        w_ge    = 40'(r2_vco) >= w_hi;
        w_m     = 63'(r3_fbm) * 63'(i_recip);
        w_qp    = 37'(r4_q0) * 37'(i_prod);
        w_r     = 37'(r4_fbm) - w_qp;
        w_got   = r4_q0 + 31'(w_r >= 37'(i_prod));
        w_got32 = {1'b0, r5_got};
        w_err   = (w_got32 >= i_tgt5) ? (w_got32 - i_tgt5) : (i_tgt5 - w_got32);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_inr <= w_inr;
            r1_vco <= w_vco[30:0];
        end
        if (i_en[2]) begin
            r2_inr <= r1_inr;
            r2_vco <= r1_vco;
            r2_q0  <= w_q[39:32];
        end
        if (i_en[3]) begin
            r3_inr <= r2_inr;
            r3_fb  <= w_ge ? w_q1[7:0] : r2_q0;
            r3_fbm <= w_ge ? w_hi[30:0] : w_lo[30:0];
        end
        if (i_en[4]) begin
            r4_inr <= r3_inr;
            r4_fb  <= r3_fb;
            r4_fbm <= r3_fbm;
            r4_q0  <= w_m[62:32];
        end
        if (i_en[5]) begin
            r5_inr <= r4_inr;
            r5_fb  <= r4_fb;
            r5_got <= w_got;
        end
        if (i_en[6]) begin
            r6_res.hit <= r5_inr && (w_err < (i_tgt5 >> 7));
            r6_res.fb  <= r5_fb;
            r6_res.got <= r5_got;
        end
    end

    assign o_res = r6_res;

endmodule

FILE: verif/tb.sv
// Testbench for pll_divider_search: drives target frequencies, predicts divider search results.
// Depends on the RTL top level only; self-checking scoreboard class inside.
module tb;

    class divider_scoreboard;
        logic [47:0] expected_data[$];
        logic        expected_found[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function void note_target(input logic [31:0] target);
            logic [63:0] vco, fb, got, err, lim, prod;
            logic [47:0] d;
            logic        hit;
            d = '0;
            hit = 1'b0;
            lim = 64'(target) >> 7;
            for (int a = 7; a >= 1; a--) begin
                for (int b = a; b >= 1; b--) begin
                    prod = 64'(a * b);
                    vco = 64'(target) * prod;
                    if (!hit && vco >= 64'd400000000 && vco <= 64'd1600000000) begin
                        fb = vco / 64'd12000000;
                        got = (fb * 64'd12000000) / prod;
                        err = (got >= 64'(target)) ? got - 64'(target) : 64'(target) - got;
                        if (err < lim) begin
                            hit = 1'b1;
                            d[7:0] = fb[7:0];
                            d[10:8] = 3'(a);
                            d[13:11] = 3'(b);
                            d[44:14] = got[30:0];
                        end
                    end
                end
            end
            expected_data.push_back(d);
            expected_found.push_back(hit);
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(input logic [47:0] data, input logic found);
            logic [47:0] d;
            if (expected_data.size() == 0) begin
                report("result with none expected");
                return;
            end
            d = expected_data.pop_front();
            if (found !== expected_found.pop_front())
                report($sformatf("found got %b", found));
            if (data[7:0] !== d[7:0])
                report($sformatf("feedback got %0d want %0d", data[7:0], d[7:0]));
            if (data[10:8] !== d[10:8])
                report($sformatf("post_div_one got %0d want %0d", data[10:8], d[10:8]));
            if (data[13:11] !== d[13:11])
                report($sformatf("post_div_two got %0d want %0d", data[13:11], d[13:11]));
            if (data[44:14] !== d[44:14])
                report($sformatf("achieved got %0d want %0d", data[44:14], d[44:14]));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    divider_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_off = 0;

    pll_divider_search uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task send_target(input logic [31:0] target);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= target;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_target(target);
    endtask

    function automatic logic [31:0] random_target();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(1700000000, 57000000);
            2: return $urandom_range(1000000, 8000000);
            3: return 32'(12000000 * $urandom_range(1, 133)) / 32'($urandom_range(1, 49));
            default: return $urandom_range(1600000000, 8000000);
        endcase
    endfunction

    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_data.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] directed[$];
        directed = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd57142857, 32'd57142856, 32'd8163265,
                     32'd8163266, 32'd400000000, 32'd1600000000, 32'd1600000001,
                     32'd12000000, 32'd100000000, 32'd48000000, 32'd200000000,
                     32'd1000000000, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'd25000000, 32'd33333333};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k])
            send_target(directed[k]);
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 72 : 30) : 0;
            stall_pct = (phase == 2) ? 72 : ((phase == 3) ? 30 : 0);
            if (phase == 2)
                hold_off = 60;
            for (int n = 0; n < 220; n++)
                send_target(random_target());
            drain();
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_data.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule
